@@ src/assert_macros.svh @@
// assertion macros for the rtl decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ADX_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("adx assertion failed");

// checked on every clock edge, reset included
`define ADX_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("adx assertion failed");

`endif

@@ src/adx_pkg.sv @@
`timescale 1ns / 1ps

package adx_pkg;

  // channel history storage
  localparam int MAX_CHANNELS = 2;
  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // payload widths
  localparam int BYTE_W   = 8;
  localparam int SAMPLE_W = 16;
  localparam int SCALE_W  = 16;
  localparam int NIB_W    = 4;

  // configuration register widths
  localparam int BB_W    = 8;
  localparam int CC_W    = 2;
  localparam int COEFF_W = 13;

  // apb port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  // datapath
  localparam int FRAC_BITS = 12;
  localparam int MUL_W     = 17;
  localparam int ACC_W     = 31;

  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;
  localparam int BB_MIN     = 3;

  // reset values of the configuration registers
  localparam logic [BB_W-1:0]           BB_RESET = 8'd18;
  localparam logic [CC_W-1:0]           CC_RESET = 2'd2;
  localparam logic [COEFF_W-1:0]        C1_RESET = 13'd7334;
  localparam logic signed [COEFF_W-1:0] C2_RESET = -13'sd3283;

  // register index within the apb map
  typedef enum logic [1:0] {
    REG_BLOCK_BYTES   = 2'd0,
    REG_CHANNEL_COUNT = 2'd1,
    REG_COEFF_FIRST   = 2'd2,
    REG_COEFF_SECOND  = 2'd3
  } cfg_reg_e;

endpackage

@@ src/adx_if.sv @@
`timescale 1ns / 1ps

// byte stream request channel
interface adx_in_if;
  logic                          valid;
  logic                          ready;
  logic [adx_pkg::BYTE_W-1:0]    stream_byte;
  logic                          restart;

  modport source (output valid, output stream_byte, output restart, input ready);
  modport sink   (input valid, input stream_byte, input restart, output ready);
endinterface

// decoded sample channel
interface adx_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [adx_pkg::SAMPLE_W-1:0] sample;
  logic                                channel;
  logic                                last_of_byte;
  logic                                frame_end;

  modport source (output valid, output sample, output channel, output last_of_byte,
                  output frame_end, input ready);
  modport sink   (input valid, input sample, input channel, input last_of_byte,
                  input frame_end, output ready);
endinterface

@@ src/adx_adpcm_block_decoder.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// ADX ADPCM block decoder: takes one stream byte per request and returns two
// 16-bit samples for every data byte, none for the two scale bytes that open
// each channel block. A data byte keeps the input side busy until the sample
// consumer has taken its second sample: each of its two samples passes three
// times through a single shared 17x17 multiplier (weight on previous sample,
// weight on the one before, nibble times scale), then passes the saturation
// state and waits in the output register until taken. The user must write
// configuration over the apb port only while the block is idle; the block
// does not enforce this. pready is always high.
module adx_adpcm_block_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [adx_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [adx_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [adx_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  // streams
  adx_in_if.sink                           in_req,
  adx_out_if.source                        out_res
);

  localparam int CH_W  = adx_pkg::CH_W;
  localparam int ACC_W = adx_pkg::ACC_W;
  localparam int MUL_W = adx_pkg::MUL_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC1,
    ST_MAC2,
    ST_MAC3,
    ST_SAT,
    ST_OUT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [adx_pkg::BB_W-1:0]           bb_q;
  logic [adx_pkg::CC_W-1:0]           cc_q;
  logic [adx_pkg::COEFF_W-1:0]        c1_q;
  logic signed [adx_pkg::COEFF_W-1:0] c2_q;

  // stream position
  logic [adx_pkg::BB_W-1:0]    pos_q;
  logic [CH_W-1:0]             ch_q;
  logic [adx_pkg::SCALE_W-1:0] scale_q;

  // per-channel history
  logic signed [adx_pkg::SAMPLE_W-1:0] hist1_q [adx_pkg::MAX_CHANNELS];
  logic signed [adx_pkg::SAMPLE_W-1:0] hist2_q [adx_pkg::MAX_CHANNELS];

  // work registers of the data byte in flight
  logic [adx_pkg::BYTE_W-1:0] work_byte_q;
  logic [CH_W-1:0]            work_ch_q;
  logic                       work_fend_q;
  logic                       half_q;
  logic signed [ACC_W-1:0]    acc_q;

  // output register
  logic                                out_valid_q;
  logic signed [adx_pkg::SAMPLE_W-1:0] out_sample_q;
  logic                                out_ch_q;
  logic                                out_last_q;
  logic                                out_fend_q;

  // apb decode
  adx_pkg::cfg_reg_e cfg_idx;
  logic              cfg_we;

  assign cfg_idx = adx_pkg::cfg_reg_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register readback
  always_comb begin
    unique case (cfg_idx)
      adx_pkg::REG_BLOCK_BYTES:   prdata = adx_pkg::APB_DATA_W'(bb_q);
      adx_pkg::REG_CHANNEL_COUNT: prdata = adx_pkg::APB_DATA_W'(cc_q);
      adx_pkg::REG_COEFF_FIRST:   prdata = adx_pkg::APB_DATA_W'(c1_q);
      adx_pkg::REG_COEFF_SECOND:  prdata = adx_pkg::APB_DATA_W'($unsigned(c2_q));
      default:                    prdata = '0;
    endcase
  end

  // effective position of the incoming byte
  logic                     in_fire;
  logic [adx_pkg::BB_W-1:0] pos_eff;
  logic [CH_W-1:0]          ch_eff;
  logic [adx_pkg::BB_W-1:0] bb_eff;
  logic [adx_pkg::CC_W-1:0] cc_eff;
  logic                     block_done;
  logic                     frame_done;

  assign in_fire = in_req.valid && in_req.ready;
  assign pos_eff = in_req.restart ? '0 : pos_q;

  always_comb begin
    if (in_req.restart || int'(ch_q) >= adx_pkg::MAX_CHANNELS) begin
      ch_eff = '0;
    end else begin
      ch_eff = ch_q;
    end
    bb_eff = (int'(bb_q) < adx_pkg::BB_MIN) ? adx_pkg::BB_W'(adx_pkg::BB_MIN) : bb_q;
    if (cc_q == '0) begin
      cc_eff = adx_pkg::CC_W'(1);
    end else if (int'(cc_q) > adx_pkg::MAX_CHANNELS) begin
      cc_eff = adx_pkg::CC_W'(adx_pkg::MAX_CHANNELS);
    end else begin
      cc_eff = cc_q;
    end
  end

  assign block_done = (int'(pos_eff) + 1) >= int'(bb_eff);
  assign frame_done = block_done && ((int'(ch_eff) + 1) >= int'(cc_eff));

  // shared multiplier operand select
  logic signed [adx_pkg::NIB_W-1:0]     nibble;
  logic signed [MUL_W-1:0]              mul_a;
  logic signed [MUL_W-1:0]              mul_b;
  logic signed [2*MUL_W-1:0]            product;
  logic signed [adx_pkg::SAMPLE_W-1:0]  h1_rd;
  logic signed [adx_pkg::SAMPLE_W-1:0]  h2_rd;

  assign nibble = half_q ? $signed(work_byte_q[3:0]) : $signed(work_byte_q[7:4]);
  assign h1_rd  = hist1_q[work_ch_q];
  assign h2_rd  = hist2_q[work_ch_q];

  always_comb begin
    unique case (state_q)
      ST_MAC1: begin
        mul_a = $signed(MUL_W'(c1_q));
        mul_b = MUL_W'(h1_rd);
      end
      ST_MAC2: begin
        mul_a = MUL_W'(c2_q);
        mul_b = MUL_W'(h2_rd);
      end
      ST_MAC3: begin
        mul_a = MUL_W'(nibble);
        mul_b = $signed(MUL_W'(scale_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  // accumulator next value and saturation
  logic signed [ACC_W-1:0]             acc_shift;
  logic signed [adx_pkg::SAMPLE_W-1:0] sat_val;

  assign acc_shift = acc_q >>> adx_pkg::FRAC_BITS;

  always_comb begin
    if (acc_q > ACC_W'(adx_pkg::SAMPLE_MAX)) begin
      sat_val = adx_pkg::SAMPLE_W'(adx_pkg::SAMPLE_MAX);
    end else if (acc_q < ACC_W'(adx_pkg::SAMPLE_MIN)) begin
      sat_val = adx_pkg::SAMPLE_W'(adx_pkg::SAMPLE_MIN);
    end else begin
      sat_val = adx_pkg::SAMPLE_W'(acc_q);
    end
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bb_q        <= adx_pkg::BB_RESET;
      cc_q        <= adx_pkg::CC_RESET;
      c1_q        <= adx_pkg::C1_RESET;
      c2_q        <= adx_pkg::C2_RESET;
      pos_q       <= '0;
      ch_q        <= '0;
      scale_q     <= '0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < adx_pkg::MAX_CHANNELS; i++) begin
        hist1_q[i] <= '0;
        hist2_q[i] <= '0;
      end
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_idx)
          adx_pkg::REG_BLOCK_BYTES:   bb_q <= pwdata[adx_pkg::BB_W-1:0];
          adx_pkg::REG_CHANNEL_COUNT: cc_q <= pwdata[adx_pkg::CC_W-1:0];
          adx_pkg::REG_COEFF_FIRST:   c1_q <= pwdata[adx_pkg::COEFF_W-1:0];
          adx_pkg::REG_COEFF_SECOND:  c2_q <= $signed(pwdata[adx_pkg::COEFF_W-1:0]);
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_req.restart) begin
              for (int i = 0; i < adx_pkg::MAX_CHANNELS; i++) begin
                hist1_q[i] <= '0;
                hist2_q[i] <= '0;
              end
            end
            // scale bytes, then data bytes
            if (pos_eff == '0) begin
              scale_q <= {in_req.stream_byte, scale_q[7:0]};
            end else if (pos_eff == adx_pkg::BB_W'(1)) begin
              scale_q <= {scale_q[15:8], in_req.stream_byte};
            end else begin
              work_byte_q <= in_req.stream_byte;
              work_ch_q   <= ch_eff;
              work_fend_q <= frame_done;
              half_q      <= 1'b0;
              state_q     <= ST_MAC1;
            end
            // advance block position
            if (block_done) begin
              pos_q <= '0;
              ch_q  <= frame_done ? '0 : CH_W'(int'(ch_eff) + 1);
            end else begin
              pos_q <= pos_eff + adx_pkg::BB_W'(1);
              ch_q  <= ch_eff;
            end
          end
        end
        ST_MAC1: begin
          acc_q   <= ACC_W'(product);
          state_q <= ST_MAC2;
        end
        ST_MAC2: begin
          acc_q   <= acc_q + ACC_W'(product);
          state_q <= ST_MAC3;
        end
        ST_MAC3: begin
          acc_q   <= acc_shift + ACC_W'(product);
          state_q <= ST_SAT;
        end
        ST_SAT: begin
          hist2_q[work_ch_q] <= h1_rd;
          hist1_q[work_ch_q] <= sat_val;
          out_sample_q       <= sat_val;
          out_ch_q           <= work_ch_q[0];
          out_last_q         <= half_q;
          out_fend_q         <= half_q && work_fend_q;
          out_valid_q        <= 1'b1;
          state_q            <= ST_OUT;
        end
        ST_OUT: begin
          if (out_res.ready) begin
            out_valid_q <= 1'b0;
            if (half_q) begin
              state_q <= ST_IDLE;
            end else begin
              half_q  <= 1'b1;
              state_q <= ST_MAC1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // port drive
  assign in_req.ready         = (state_q == ST_IDLE);
  assign out_res.valid        = out_valid_q;
  assign out_res.sample       = out_sample_q;
  assign out_res.channel      = out_ch_q;
  assign out_res.last_of_byte = out_last_q;
  assign out_res.frame_end    = out_fend_q;

  // checks
  `ADX_ASSERT(a_busy_excl, !(in_req.ready && out_res.valid))
  `ADX_ASSERT(a_out_from_sat, $rose(out_valid_q) |-> $past(state_q == ST_SAT))
  `ADX_ASSERT(a_last_frees, out_res.valid && out_res.ready && out_res.last_of_byte |=> in_req.ready)
  `ADX_ASSERT(a_fend_on_last, out_res.valid && out_res.frame_end |-> out_res.last_of_byte)
  `ADX_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_res.valid && state_q == ST_IDLE)

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import adx_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES  = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int RAND_PHASES  = 10;
  localparam int LONG_PHASE   = 5;
  localparam int PRESS_PHASE  = 2;
  localparam int DIR_ROWS     = 40;

  // one decoded sample as seen on the result channel
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       channel;
    logic                       last_of_byte;
    logic                       frame_end;
  } pcm_t;

  // one stream byte request, optionally with hand-written expectations
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              restart;
    logic              typed;
    pcm_t              exp_a;
    pcm_t              exp_b;
  } byte_req_t;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [BYTE_W-1:0] data;
    logic              restart;
    cfg_reg_e          idx;
    logic [31:0]       value;
    logic              typed;
    pcm_t              exp_a;
    pcm_t              exp_b;
  } dir_row_t;

  typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_MOSTLY} stall_mode_e;

  localparam pcm_t PCM_NONE    = '0;
  localparam pcm_t PCM_MIN_HI  = {16'h8000, 1'b0, 1'b0, 1'b0};
  localparam pcm_t PCM_MIN_LO  = {16'h8000, 1'b0, 1'b1, 1'b0};
  localparam pcm_t PCM_ZERO_HI = {16'h0000, 1'b0, 1'b0, 1'b0};
  localparam pcm_t PCM_ZERO_LO = {16'h0000, 1'b0, 1'b1, 1'b0};

  // directed stimulus: config writes and stream bytes in order
  dir_row_t dir_tab [DIR_ROWS] = '{
    // reset settings, full scale negative saturation, then zero scale
    '{ROW_BYTE, 8'hFF, 1'b1, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'hFF, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h80, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b1, PCM_MIN_HI, PCM_MIN_LO},
    '{ROW_BYTE, 8'h7F, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h00, 1'b1, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h00, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h00, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b1, PCM_ZERO_HI, PCM_ZERO_LO},
    // short block and zero channels, extreme weights
    '{ROW_CFG, 8'h00, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_CFG, 8'h00, 1'b0, REG_CHANNEL_COUNT, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_CFG, 8'h00, 1'b0, REG_COEFF_FIRST, 32'd8191, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_CFG, 8'h00, 1'b0, REG_COEFF_SECOND, 32'h1000, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h7F, 1'b1, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'hFF, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'hF7, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h00, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h40, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h08, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    // minimum block, too many channels, zero weights
    '{ROW_CFG, 8'h00, 1'b0, REG_BLOCK_BYTES, 32'd3, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_CFG, 8'h00, 1'b0, REG_CHANNEL_COUNT, 32'd3, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_CFG, 8'h00, 1'b0, REG_COEFF_FIRST, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_CFG, 8'h00, 1'b0, REG_COEFF_SECOND, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h12, 1'b1, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h34, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'hA5, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h56, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h78, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h5A, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    // block length shrunk below the current position
    '{ROW_CFG, 8'h00, 1'b0, REG_BLOCK_BYTES, 32'd10, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_CFG, 8'h00, 1'b0, REG_COEFF_FIRST, 32'd7334, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_CFG, 8'h00, 1'b0, REG_COEFF_SECOND, 32'h132D, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h01, 1'b1, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h00, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h1E, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'hE1, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_CFG, 8'h00, 1'b0, REG_BLOCK_BYTES, 32'd3, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h4B, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    // channel count dropped while on the second channel
    '{ROW_CFG, 8'h00, 1'b0, REG_CHANNEL_COUNT, 32'd1, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h00, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h20, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE},
    '{ROW_BYTE, 8'h87, 1'b0, REG_BLOCK_BYTES, 32'd0, 1'b0, PCM_NONE, PCM_NONE}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  adx_in_if  in_req ();
  adx_out_if out_res ();

  adx_adpcm_block_decoder u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_req  (in_req),
    .out_res (out_res)
  );

  always #5ns clk_i = ~clk_i;

  // decoder shadow: configuration and stream state
  logic [BB_W-1:0]             cfg_bb = BB_RESET;
  logic [CC_W-1:0]             cfg_cc = CC_RESET;
  logic [COEFF_W-1:0]          cfg_c1 = C1_RESET;
  logic signed [COEFF_W-1:0]   cfg_c2 = C2_RESET;
  logic [BB_W-1:0]             dec_pos = '0;
  logic                        dec_ch = 1'b0;
  logic [SCALE_W-1:0]          dec_scale = '0;
  logic signed [SAMPLE_W-1:0]  prev_one [MAX_CHANNELS] = '{default: '0};
  logic signed [SAMPLE_W-1:0]  prev_two [MAX_CHANNELS] = '{default: '0};

  byte_req_t byte_q [$];
  pcm_t      pcm_q [$];
  int        gen_pos = 0;
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  bit        hold_req = 1'b0;

  // one nibble through the predictor, history updated
  function automatic logic signed [SAMPLE_W-1:0] adpcm_nibble(logic ch, logic [3:0] nib);
    logic signed [3:0]          nib_s;
    logic signed [SAMPLE_W-1:0] s;
    longint                     n, sc, w1, w2, h1, h2, acc, sum;
    nib_s = nib;
    n  = longint'(nib_s);
    sc = longint'(dec_scale);
    w1 = longint'(cfg_c1);
    w2 = longint'(cfg_c2);
    h1 = longint'(prev_one[ch]);
    h2 = longint'(prev_two[ch]);
    acc = w1 * h1 + w2 * h2;
    sum = n * sc + (acc >>> FRAC_BITS);
    if (sum > SAMPLE_MAX) s = SAMPLE_W'(SAMPLE_MAX);
    else if (sum < SAMPLE_MIN) s = SAMPLE_W'(SAMPLE_MIN);
    else s = sum[SAMPLE_W-1:0];
    prev_two[ch] = prev_one[ch];
    prev_one[ch] = s;
    return s;
  endfunction

  // one stream byte: returns the number of samples it yields
  function automatic int decode_byte(logic [BYTE_W-1:0] b, logic rst_flag,
                                     output pcm_t ra, output pcm_t rb);
    int   blen, nch;
    logic ch;
    bit   blk_done, frm_done;
    int   cnt;
    cnt  = 0;
    ra   = '0;
    rb   = '0;
    blen = (cfg_bb < BB_MIN) ? BB_MIN : int'(cfg_bb);
    nch  = int'(cfg_cc);
    if (nch < 1) nch = 1;
    if (nch > MAX_CHANNELS) nch = MAX_CHANNELS;
    if (rst_flag) begin
      prev_one = '{default: '0};
      prev_two = '{default: '0};
      dec_pos  = '0;
      dec_ch   = 1'b0;
    end
    ch       = dec_ch;
    blk_done = (int'(dec_pos) + 1) >= blen;
    frm_done = blk_done && ((int'(ch) + 1) >= nch);
    if (dec_pos == 0) begin
      dec_scale = {b, 8'h00};
    end else if (dec_pos == 1) begin
      dec_scale[7:0] = b;
    end else begin
      ra.sample       = adpcm_nibble(ch, b[7:4]);
      ra.channel      = ch;
      rb.sample       = adpcm_nibble(ch, b[3:0]);
      rb.channel      = ch;
      rb.last_of_byte = 1'b1;
      rb.frame_end    = frm_done;
      cnt = 2;
    end
    if (blk_done) begin
      dec_pos = '0;
      dec_ch  = frm_done ? 1'b0 : ch + 1'b1;
    end else begin
      dec_pos = dec_pos + 1'b1;
    end
    return cnt;
  endfunction

  // apb write: setup, access, then update the shadow settings
  task automatic cfg_write(cfg_reg_e idx, logic [APB_DATA_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_BLOCK_BYTES:   cfg_bb = val[BB_W-1:0];
      REG_CHANNEL_COUNT: cfg_cc = val[CC_W-1:0];
      REG_COEFF_FIRST:   cfg_c1 = val[COEFF_W-1:0];
      REG_COEFF_SECOND:  cfg_c2 = val[COEFF_W-1:0];
      default: ;
    endcase
  endtask

  // block drained: no byte pending, no sample outstanding, then a short tail
  task automatic wait_idle();
    while (byte_q.size() != 0 || pcm_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // random bytes laid out as frames, small scales mostly, stray restarts if noisy
  task automatic queue_random(int n, bit lead_restart, bit noisy);
    byte_req_t it;
    int        blen;
    for (int i = 0; i < n; i++) begin
      it = '0;
      it.restart = (i == 0 && lead_restart) || (noisy && $urandom_range(0, 39) == 0);
      if (it.restart) gen_pos = 0;
      if (gen_pos == 0)
        it.data = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 1));
      else
        it.data = 8'($urandom);
      blen = (cfg_bb < BB_MIN) ? BB_MIN : int'(cfg_bb);
      gen_pos = (gen_pos + 1 >= blen) ? 0 : gen_pos + 1;
      byte_q.push_back(it);
    end
  endtask

  // byte sender: bursts and gaps, valid held until the request is taken
  initial begin : sender
    int        burst_left, gap_left, got_n;
    pcm_t      ra, rb;
    byte_req_t cur;
    burst_left = 0;
    gap_left   = 0;
    in_req.valid       <= 1'b0;
    in_req.stream_byte <= '0;
    in_req.restart     <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (in_req.valid && in_req.ready) begin
        cur   = byte_q.pop_front();
        got_n = decode_byte(cur.data, cur.restart, ra, rb);
        if (cur.typed) begin
          pcm_q.push_back(cur.exp_a);
          pcm_q.push_back(cur.exp_b);
        end else if (got_n == 2) begin
          pcm_q.push_back(ra);
          pcm_q.push_back(rb);
        end
        if (burst_left > 0) burst_left--;
      end
      if (!(in_req.valid && !in_req.ready)) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_req.valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          in_req.valid       <= 1'b1;
          in_req.stream_byte <= byte_q[0].data;
          in_req.restart     <= byte_q[0].restart;
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // sample consumer: changing stall patterns plus an occasional long hold-off
  initial begin : consumer
    stall_mode_e mode;
    int          mode_left, hold_left;
    mode      = RDY_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_res.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
          RDY_ALWAYS: out_res.ready <= 1'b1;
          RDY_HALF:   out_res.ready <= 1'($urandom_range(0, 1));
          RDY_SPARSE: out_res.ready <= ($urandom_range(0, 3) == 0);
          default:    out_res.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // sample checker against the oldest outstanding expectation
  always @(posedge clk_i) begin : result_check
    pcm_t got, want;
    if (rst_ni && out_res.valid && out_res.ready) begin
      got = {out_res.sample, out_res.channel, out_res.last_of_byte, out_res.frame_end};
      if (pcm_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected sample %0d ch %0d lob %0d fe %0d", got.sample, got.channel,
                   got.last_of_byte, got.frame_end);
      end else begin
        want = pcm_q.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp %0d ch %0d lob %0d fe %0d, got %0d ch %0d lob %0d fe %0d",
                     want.sample, want.channel, want.last_of_byte, want.frame_end,
                     got.sample, got.channel, got.last_of_byte, got.frame_end);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // reset, directed table, random phases, drain
  initial begin : main
    int v;
    rst_ni  <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(dir_tab[i].idx, dir_tab[i].value);
      end else begin
        byte_q.push_back({dir_tab[i].data, dir_tab[i].restart, dir_tab[i].typed,
                          dir_tab[i].exp_a, dir_tab[i].exp_b});
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      if (ph == LONG_PHASE) begin
        // longest block, one channel, no stray restarts
        cfg_write(REG_BLOCK_BYTES, 32'd255);
        cfg_write(REG_CHANNEL_COUNT, 32'd1);
        queue_random(260, 1'b1, 1'b0);
      end else begin
        if ($urandom_range(0, 1) == 1) begin
          case ($urandom_range(0, 7))
            0:       v = $urandom_range(0, 2);
            1:       v = BB_MIN;
            2:       v = $urandom_range(20, 60);
            default: v = $urandom_range(3, 12);
          endcase
          cfg_write(REG_BLOCK_BYTES, 32'(v));
        end
        if ($urandom_range(0, 1) == 1)
          cfg_write(REG_CHANNEL_COUNT, 32'($urandom_range(0, 3)));
        if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = 8191;
            2:       v = $urandom_range(0, 8191);
            default: v = $urandom_range(7000, 7600);
          endcase
          cfg_write(REG_COEFF_FIRST, 32'(v));
        end
        if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 5))
            0:       v = -4096;
            1:       v = 0;
            2:       v = -int'($urandom_range(0, 4096));
            default: v = -int'($urandom_range(3000, 3500));
          endcase
          cfg_write(REG_COEFF_SECOND, 32'(v[COEFF_W-1:0]));
        end
        // consumer stops for a while so the decoder backs up into the sender
        if (ph == PRESS_PHASE) hold_req = 1'b1;
        queue_random(40, $urandom_range(0, 2) != 0, 1'b1);
      end
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
